// ===== src/dss_pkg.sv =====
// Shared types, constants and the digit font for the decimal seven-segment scan block.
package dss_pkg;

    localparam int VALUE_W         = 27;
    localparam int DIGIT_W         = 4;
    localparam int CHUNK_BITS      = 4;
    localparam int PADDED_W        = 28;
    localparam int CHUNK_COUNT     = PADDED_W / CHUNK_BITS;
    localparam int DIGIT_COUNT_DEF = 8;
    localparam int INDEX_W         = 3;
    localparam int SELECT_W        = 8;
    localparam int SEG_W           = 7;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== src/dss_bcd_cell.sv =====
// One decimal digit cell of the shift-and-add-3 conversion chain.
module dss_bcd_cell
    import dss_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [CHUNK_BITS-1:0] i_bits,
    output logic [CHUNK_BITS-1:0] o_bits,
    output logic [DIGIT_W-1:0]    o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;

    // Four correct-then-shift steps; bits arrive and leave most significant first.
    always_comb begin
        n_digit = r_digit;
        for (int j = 0; j < CHUNK_BITS; j++) begin
            if (n_digit >= 4'd5) begin
                n_digit = n_digit + 4'd3;
            end
            o_bits[CHUNK_BITS-1-j] = n_digit[DIGIT_W-1];
            n_digit = {n_digit[DIGIT_W-2:0], i_bits[CHUNK_BITS-1-j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// ===== src/decimal_seven_segment_scan.sv =====
// Top level of the decimal seven-segment scan: binary to decimal digits, one word per digit.
//
// The input channel (i_valid, o_stall, i_value) takes one binary word. A value above the
// largest number that DIGIT_COUNT digits can show is saturated to all nines, and every
// digit word of that value carries o_overflow. The output channel (o_valid, i_stall and
// the o_ fields) then gives DIGIT_COUNT words, most significant digit first, each with
// its position, an active-low digit select and the segment code; the final one has o_last.
//
// The conversion runs in a row of digit cells that pass four binary bits up the row every
// cycle while shifting. When the shifting ends, the digits wait in the cell row until the
// output stage is free and takes them. The converter takes the next value while the
// previous one is still being shown.
//
// Reset returns the converter and the output stage to empty; no word is in flight after
// it. When the receiver stalls, the current digit word holds, a finished conversion waits
// in the cell row, and o_stall rises until the output stage can take it.
module decimal_seven_segment_scan
    import dss_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [INDEX_W-1:0]  o_digit_index,
    output logic [SELECT_W-1:0] o_digit_select,
    output logic [SEG_W-1:0]    o_segments,
    output logic                o_overflow,
    output logic                o_last
);

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam logic [VALUE_W-1:0] TOP_VALUE = VALUE_W'(pow10(DIGIT_COUNT) - 1);
    localparam int                 CNT_W     = $clog2(CHUNK_COUNT);
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(CHUNK_COUNT - 1);
    localparam logic [INDEX_W-1:0] IDX_LAST  = INDEX_W'(DIGIT_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_conv_state;

    t_conv_state          r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [PADDED_W-1:0]  r_bin;
    logic                 r_conv_ovf;

    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_idx;
    logic                 r_out_ovf;
    logic [DIGIT_W-1:0]   r_out_digits [DIGIT_COUNT];

    logic                 w_out_free;
    logic                 w_handoff;
    logic                 w_conv_free;
    logic                 w_accept;
    logic                 w_sat;
    logic [VALUE_W-1:0]   w_sat_value;
    t_cell_ctrl           w_cell_ctrl;

    logic [CHUNK_BITS-1:0] w_chain      [DIGIT_COUNT];
    logic [DIGIT_W-1:0]    w_cell_digit [DIGIT_COUNT];

    // The output stage is free when empty or when its final digit leaves this cycle.
    assign o_last      = (r_idx == IDX_LAST);
    assign w_out_free  = !r_out_valid || (!i_stall && o_last);
    assign w_handoff   = (r_state == S_DONE) && w_out_free;
    assign w_conv_free = (r_state == S_IDLE) || w_handoff;
    assign o_stall     = !w_conv_free;
    assign w_accept    = i_valid && w_conv_free;

    assign w_sat       = (i_value > TOP_VALUE);
    assign w_sat_value = w_sat ? TOP_VALUE : i_value;

    assign w_cell_ctrl.clear = w_accept;
    assign w_cell_ctrl.shift = (r_state == S_SHIFT);

    // Binary bits enter the least significant digit cell four at a time.
    assign w_chain[0] = r_bin[PADDED_W-1 -: CHUNK_BITS];

    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
        if (k < DIGIT_COUNT - 1) begin : g_link
            dss_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_cell_ctrl),
                .i_bits  (w_chain[k]),
                .o_bits  (w_chain[k+1]),
                .o_digit (w_cell_digit[k])
            );
        end else begin : g_top
            // Only zeros leave the most significant cell, since the value is saturated.
            dss_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_cell_ctrl),
                .i_bits  (w_chain[k]),
                .o_bits  (),
                .o_digit (w_cell_digit[k])
            );
        end
    end

    // Converter sequencer: load, shift, then wait for the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            if (w_accept) begin
                r_state <= S_SHIFT;
                r_cnt   <= '0;
            end else if (w_handoff) begin
                r_state <= S_IDLE;
            end else if (r_state == S_SHIFT) begin
                if (r_cnt == CNT_LAST) begin
                    r_state <= S_DONE;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin      <= {{(PADDED_W - VALUE_W){1'b0}}, w_sat_value};
            r_conv_ovf <= w_sat;
        end else if (r_state == S_SHIFT) begin
            r_bin <= {r_bin[PADDED_W-CHUNK_BITS-1:0], {CHUNK_BITS{1'b0}}};
        end
    end

    // Output stage: the digits shift toward slot zero as each word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (w_handoff) begin
            r_out_valid <= 1'b1;
            r_idx       <= '0;
        end else if (r_out_valid && !i_stall) begin
            if (o_last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_handoff) begin
            r_out_ovf <= r_conv_ovf;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_out_digits[i] <= w_cell_digit[DIGIT_COUNT-1-i];
            end
        end else if (r_out_valid && !i_stall) begin
            for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                r_out_digits[i] <= r_out_digits[i+1];
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_digit_index  = r_idx;
    assign o_digit_select = SELECT_W'(~({{(SELECT_W-1){1'b0}}, 1'b1} << r_idx));
    assign o_segments     = seg_font(r_out_digits[0]);
    assign o_overflow     = r_out_ovf;

endmodule
